// ===== src/mac_pkg.sv =====
// ============================================================================
// mac_pkg
// Shared types and constants for the moving-average crossover detector.
// ============================================================================
package mac_pkg;

    // Sample width and default ring depth
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_WINDOW  = 256;

    // Configuration register widths and reset values
    localparam int FAST_W      = 8;
    localparam int SLOW_W      = 9;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 9;
    localparam logic [FAST_W-1:0] FAST_RESET = FAST_W'(5);
    localparam logic [SLOW_W-1:0] SLOW_RESET = SLOW_W'(20);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FAST_LEN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_LEN = CFG_IDX_W'(1);

    // Crossing kinds
    localparam logic CROSS_GOLDEN = 1'b0;
    localparam logic CROSS_DEATH  = 1'b1;

    // Input request
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   first_of_series;
    } t_in;

    // Output request
    typedef struct packed {
        logic [31:0] sample_index;
        logic        cross_kind;
    } t_out;

    // Control carried from the ring access stage to the sum stage
    typedef struct packed {
        logic                   valid;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   sub_fast;
        logic                   sub_slow;
        logic                   upd;
        logic                   chk;
        logic                   restart;
        logic [31:0]            idx;
    } t_s1_ctl;

    // Control carried from the sum stage to the crossing stages
    typedef struct packed {
        logic        valid;
        logic        chk;
        logic        restart;
        logic [31:0] idx;
    } t_s2_ctl;

endpackage

// ===== src/mac_ring.sv =====
// ============================================================================
// mac_ring
// Sample ring: one write port, two registered read ports (read-first).
// ============================================================================
module mac_ring #(
    parameter int DEPTH  = mac_pkg::MAX_WINDOW,
    parameter int ADDR_W = $clog2(mac_pkg::MAX_WINDOW)
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic                            i_we,
    input  logic [ADDR_W-1:0]               i_waddr,
    input  logic [mac_pkg::SAMPLE_BITS-1:0] i_wdata,
    input  logic [ADDR_W-1:0]               i_raddr_a,
    input  logic [ADDR_W-1:0]               i_raddr_b,
    output logic [mac_pkg::SAMPLE_BITS-1:0] o_rdata_a,
    output logic [mac_pkg::SAMPLE_BITS-1:0] o_rdata_b
);

    logic [mac_pkg::SAMPLE_BITS-1:0] r_mem [DEPTH];
    logic [mac_pkg::SAMPLE_BITS-1:0] r_rdata_a;
    logic [mac_pkg::SAMPLE_BITS-1:0] r_rdata_b;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read ports; a read at the write address returns the old entry
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== src/mac_sums.sv =====
// ============================================================================
// mac_sums
// Running fast and slow window sums, updated from the ring read data.
// ============================================================================
module mac_sums #(
    parameter int SUM_W = mac_pkg::SAMPLE_BITS + $clog2(mac_pkg::MAX_WINDOW)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  mac_pkg::t_s1_ctl                i_ctl,
    input  logic [mac_pkg::SAMPLE_BITS-1:0] i_rd_fast,
    input  logic [mac_pkg::SAMPLE_BITS-1:0] i_rd_slow,
    output mac_pkg::t_s2_ctl                o_ctl,
    output logic [SUM_W-1:0]                o_fast_sum,
    output logic [SUM_W-1:0]                o_slow_sum
);

    logic [SUM_W-1:0] r_fast_sum;
    logic [SUM_W-1:0] r_slow_sum;
    logic [SUM_W-1:0] n_fast_sum;
    logic [SUM_W-1:0] n_slow_sum;
    logic [SUM_W-1:0] fast_base;
    logic [SUM_W-1:0] slow_base;
    logic [SUM_W-1:0] x_ext;
    logic [SUM_W-1:0] fast_old;
    logic [SUM_W-1:0] slow_old;
    mac_pkg::t_s2_ctl r_ctl;

    // Add the new sample, drop the one leaving each window
    always_comb begin
        fast_base  = i_ctl.restart ? '0 : r_fast_sum;
        slow_base  = i_ctl.restart ? '0 : r_slow_sum;
        x_ext      = SUM_W'(i_ctl.sample);
        fast_old   = i_ctl.sub_fast ? SUM_W'(i_rd_fast) : '0;
        slow_old   = i_ctl.sub_slow ? SUM_W'(i_rd_slow) : '0;
        n_fast_sum = i_ctl.upd ? fast_base + x_ext - fast_old : fast_base;
        n_slow_sum = i_ctl.upd ? slow_base + x_ext - slow_old : slow_base;
    end

    // Sum registers double as the stage output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_sum <= '0;
            r_slow_sum <= '0;
        end else if (i_en && i_ctl.valid) begin
            r_fast_sum <= n_fast_sum;
            r_slow_sum <= n_slow_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl.valid   <= i_ctl.valid;
            r_ctl.chk     <= i_ctl.chk;
            r_ctl.restart <= i_ctl.restart;
            r_ctl.idx     <= i_ctl.idx;
        end
    end

    assign o_ctl      = r_ctl;
    assign o_fast_sum = r_fast_sum;
    assign o_slow_sum = r_slow_sum;

endmodule

// ===== src/mac_cross.sv =====
// ============================================================================
// mac_cross
// Cross-multiplied average compare, sign history and output register.
// ============================================================================
module mac_cross #(
    parameter int SUM_W = mac_pkg::SAMPLE_BITS + $clog2(mac_pkg::MAX_WINDOW)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mac_pkg::t_s2_ctl           i_ctl,
    input  logic [SUM_W-1:0]           i_fast_sum,
    input  logic [SUM_W-1:0]           i_slow_sum,
    input  logic [mac_pkg::FAST_W-1:0] i_fast_win,
    input  logic [mac_pkg::SLOW_W-1:0] i_slow_win,
    input  logic                       i_out_stall,
    output logic                       o_hold,
    output logic                       o_out_valid,
    output mac_pkg::t_out              o_out_data
);

    localparam int PROD_W = SUM_W + mac_pkg::SLOW_W;

    localparam logic [1:0] SIGN_ZERO = 2'b00;
    localparam logic [1:0] SIGN_POS  = 2'b01;
    localparam logic [1:0] SIGN_NEG  = 2'b10;

    mac_pkg::t_s2_ctl r_s3;
    logic [PROD_W-1:0] r_prod_a;
    logic [PROD_W-1:0] r_prod_b;
    logic [1:0]        r_prev_sign;
    logic              r_sign_valid;
    logic              r_out_valid;
    mac_pkg::t_out     r_out_data;

    logic       en;
    logic [1:0] cur_sign;
    logic [1:0] prev_eff;
    logic       sv_eff;
    logic       emit;

    // Stage 2: fast sum times slow length and slow sum times fast length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3 <= '0;
        end else if (en) begin
            r_s3 <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod_a <= PROD_W'(i_fast_sum) * PROD_W'(i_slow_win);
            r_prod_b <= PROD_W'(i_slow_sum) * PROD_W'(i_fast_win);
        end
    end

    // Stage 3: sign of the average difference and crossing test
    always_comb begin
        if (r_prod_a > r_prod_b) begin
            cur_sign = SIGN_POS;
        end else if (r_prod_a < r_prod_b) begin
            cur_sign = SIGN_NEG;
        end else begin
            cur_sign = SIGN_ZERO;
        end
        prev_eff = r_s3.restart ? SIGN_ZERO : r_prev_sign;
        sv_eff   = r_s3.restart ? 1'b0 : r_sign_valid;
        emit     = r_s3.valid && r_s3.chk && sv_eff &&
                   ((prev_eff != SIGN_POS && cur_sign == SIGN_POS) ||
                    (prev_eff != SIGN_NEG && cur_sign == SIGN_NEG));
    end

    // Freeze only when a crossing has nowhere to go
    assign o_hold = r_out_valid && i_out_stall && emit;
    assign en     = !o_hold;

    // Sign history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_sign  <= SIGN_ZERO;
            r_sign_valid <= 1'b0;
        end else if (en && r_s3.valid) begin
            if (r_s3.chk) begin
                r_prev_sign  <= cur_sign;
                r_sign_valid <= 1'b1;
            end else if (r_s3.restart) begin
                r_prev_sign  <= SIGN_ZERO;
                r_sign_valid <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((!r_out_valid || !i_out_stall) && emit) begin
            r_out_data.sample_index <= r_s3.idx;
            r_out_data.cross_kind   <= (cur_sign == SIGN_NEG) ? mac_pkg::CROSS_DEATH
                                                              : mac_pkg::CROSS_GOLDEN;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== src/moving_average_crossover_detector_top.sv =====
// ============================================================================
// moving_average_crossover_detector_top
// Simple moving-average crossover detector over a ring of recent samples.
// ============================================================================
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+--------------------------------
//  in      | to block  | i_in_valid / o_in_stall  | i_in_data  (sample, first)
//  out     | from block| o_out_valid / i_out_stall| o_out_data (index, kind)
//  cfg     | to block  | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
//  One sample is accepted per clock unless the input stalls; a crossing reaches
//  the output register through the stage 1, sum and product registers. The rate
//  is set by the ring, with two reads and one write each cycle, and the sum update.
//  Synchronous active-low reset clears pointers, counts, sums and sign history;
//  the ring itself is not cleared and needs no clearing pass.
//  The input stalls only while a crossing waits on a stalled output register.
//  A write to a known register restarts the series at the next sample.
//
module moving_average_crossover_detector_top #(
    parameter int MAX_WINDOW = mac_pkg::MAX_WINDOW
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  mac_pkg::t_in                      i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output mac_pkg::t_out                     o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mac_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mac_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int ADDR_W = $clog2(MAX_WINDOW);
    localparam int FILL_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W  = (FILL_W > mac_pkg::SLOW_W) ? FILL_W : mac_pkg::SLOW_W;
    localparam int SUM_W  = mac_pkg::SAMPLE_BITS + ADDR_W;

    // Configuration and series state
    logic [mac_pkg::FAST_W-1:0] r_fast_win;
    logic [mac_pkg::SLOW_W-1:0] r_slow_win;
    logic                       r_pend;
    logic [ADDR_W-1:0]          r_wp;
    logic [FILL_W-1:0]          r_fill;
    logic [31:0]                r_seen;
    mac_pkg::t_s1_ctl           r_s1;

    logic                  hold;
    logic                  en;
    logic                  in_acc;
    logic                  cfg_acc;
    logic                  restart;
    logic [ADDR_W-1:0]     wp_eff;
    logic [ADDR_W-1:0]     n_wp;
    logic [FILL_W-1:0]     fill_eff;
    logic [FILL_W-1:0]     n_fill;
    logic [31:0]           idx;
    logic [CMP_W-1:0]      wp_ext;
    logic [CMP_W-1:0]      fw_ext;
    logic [CMP_W-1:0]      sw_ext;
    logic [CMP_W-1:0]      addr_f;
    logic [CMP_W-1:0]      addr_s;
    logic                  win_ok;

    logic [mac_pkg::SAMPLE_BITS-1:0] rd_fast;
    logic [mac_pkg::SAMPLE_BITS-1:0] rd_slow;
    mac_pkg::t_s2_ctl                s2_ctl;
    logic [SUM_W-1:0]                fast_sum;
    logic [SUM_W-1:0]                slow_sum;

    assign en          = !hold;
    assign o_in_stall  = hold;
    assign in_acc      = i_in_valid && !hold;
    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    // Register writes; a write to a known register restarts the series
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_win <= mac_pkg::FAST_RESET;
            r_slow_win <= mac_pkg::SLOW_RESET;
            r_pend     <= 1'b0;
        end else if (cfg_acc) begin
            case (i_cfg_index)
                mac_pkg::REG_FAST_LEN: begin
                    r_fast_win <= i_cfg_data[mac_pkg::FAST_W-1:0];
                    r_pend     <= 1'b1;
                end
                mac_pkg::REG_SLOW_LEN: begin
                    r_slow_win <= i_cfg_data[mac_pkg::SLOW_W-1:0];
                    r_pend     <= 1'b1;
                end
                default: begin
                end
            endcase
        end else if (in_acc) begin
            r_pend <= 1'b0;
        end
    end

    // Stage 0: series bookkeeping and ring addresses
    always_comb begin
        restart  = i_in_data.first_of_series || r_pend;
        wp_eff   = restart ? '0 : r_wp;
        fill_eff = restart ? '0 : r_fill;
        idx      = restart ? '0 : r_seen;
        n_wp     = (wp_eff == ADDR_W'(MAX_WINDOW - 1)) ? '0 : wp_eff + 1'b1;
        n_fill   = (fill_eff == FILL_W'(MAX_WINDOW)) ? fill_eff : fill_eff + 1'b1;
        wp_ext   = CMP_W'(wp_eff);
        fw_ext   = CMP_W'(r_fast_win);
        sw_ext   = CMP_W'(r_slow_win);
        addr_f   = (wp_ext >= fw_ext) ? wp_ext - fw_ext
                                      : wp_ext + CMP_W'(MAX_WINDOW) - fw_ext;
        addr_s   = (wp_ext >= sw_ext) ? wp_ext - sw_ext
                                      : wp_ext + CMP_W'(MAX_WINDOW) - sw_ext;
        win_ok   = (r_fast_win != '0) && (fw_ext < sw_ext) &&
                   (sw_ext <= CMP_W'(MAX_WINDOW));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
            r_seen <= '0;
        end else if (in_acc) begin
            r_wp   <= n_wp;
            r_fill <= n_fill;
            r_seen <= idx + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else if (en) begin
            r_s1.valid    <= in_acc;
            r_s1.sample   <= i_in_data.sample;
            r_s1.sub_fast <= CMP_W'(fill_eff) >= fw_ext;
            r_s1.sub_slow <= CMP_W'(fill_eff) >= sw_ext;
            r_s1.upd      <= win_ok;
            r_s1.chk      <= win_ok && (CMP_W'(n_fill) >= sw_ext);
            r_s1.restart  <= restart;
            r_s1.idx      <= idx;
        end
    end

    mac_ring #(
        .DEPTH  (MAX_WINDOW),
        .ADDR_W (ADDR_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_we      (in_acc),
        .i_waddr   (wp_eff),
        .i_wdata   (i_in_data.sample),
        .i_raddr_a (addr_f[ADDR_W-1:0]),
        .i_raddr_b (addr_s[ADDR_W-1:0]),
        .o_rdata_a (rd_fast),
        .o_rdata_b (rd_slow)
    );

    mac_sums #(
        .SUM_W (SUM_W)
    ) u_sums (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_ctl      (r_s1),
        .i_rd_fast  (rd_fast),
        .i_rd_slow  (rd_slow),
        .o_ctl      (s2_ctl),
        .o_fast_sum (fast_sum),
        .o_slow_sum (slow_sum)
    );

    mac_cross #(
        .SUM_W (SUM_W)
    ) u_cross (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (s2_ctl),
        .i_fast_sum  (fast_sum),
        .i_slow_sum  (slow_sum),
        .i_fast_win  (r_fast_win),
        .i_slow_win  (r_slow_win),
        .i_out_stall (i_out_stall),
        .o_hold      (hold),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // Input backpressure only comes from a full, stalled output register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // Ring pointer stays inside the ring
    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= ADDR_W'(MAX_WINDOW - 1))
        else $error("ring write pointer out of range");

    // Fill count saturates at the ring depth
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(MAX_WINDOW))
        else $error("fill count beyond ring depth");

    // A new series makes the accepted sample index zero
    a_series_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && restart) |=> (r_seen == 32'd1 && r_fill == FILL_W'(1)))
        else $error("series restart not applied");

endmodule

// ===== tb/tb_moving_average_crossover_detector_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_moving_average_crossover_detector_top
// Self-checking bench for the moving-average crossover detector. A queue-fed
// driver offers samples in random bursts, and the output side stalls in
// shifting patterns with one long hold-off. A clocked monitor runs its own
// SMA crossover predictor on every accepted sample and compares each crossing
// field by field. Window registers change only between phases, once the
// block is idle.
// ============================================================================
module tb_moving_average_crossover_detector_top;

    localparam int CLK_PERIOD   = 20;
    localparam int DRAIN_CYCLES = 12;
    localparam int SETTLE_LIMIT = 50000;
    localparam int HOLD_CYCLES  = 240;

    // Register indexes with nothing behind them
    localparam logic [mac_pkg::CFG_IDX_W-1:0] REG_SPARE = mac_pkg::CFG_IDX_W'(2);
    localparam logic [mac_pkg::CFG_IDX_W-1:0] REG_LAST  = mac_pkg::CFG_IDX_W'(255);

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HALF,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_mode;

    // DUT connections
    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    mac_pkg::t_in                   in_data   = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    mac_pkg::t_out                  out_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [mac_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mac_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor state: ring, running sums, series bookkeeping, windows
    logic [mac_pkg::SAMPLE_BITS-1:0] sma_ring [mac_pkg::MAX_WINDOW];
    logic [7:0]                      sma_wp;
    logic [23:0]                     sma_fast_sum;
    logic [23:0]                     sma_slow_sum;
    logic [31:0]                     sma_seen;
    int                              sma_fill;
    int                              sma_prev_sign;
    bit                              sma_sign_valid;
    logic [mac_pkg::FAST_W-1:0]      sma_fast_win;
    logic [mac_pkg::SLOW_W-1:0]      sma_slow_win;

    // Samples waiting to be offered, crossings waiting to come out
    mac_pkg::t_in  sample_backlog[$];
    mac_pkg::t_out pending_crosses[$];

    // Run statistics
    int n_err     = 0;
    int n_samples = 0;
    int n_cfg     = 0;
    int n_golden  = 0;
    int n_death   = 0;
    int n_in_held = 0;

    // Sender and receiver pacing
    bit          in_fire    = 1'b0;
    int          burst_left = 0;
    int          gap_left   = 0;
    int          hold_asks  = 0;
    int          hold_seen  = 0;
    int          hold_left  = 0;
    int          mode_left  = 0;
    t_stall_mode stall_mode = STALL_NONE;

    moving_average_crossover_detector_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Start a new series: history, sums and sign memory cleared
    function automatic void series_restart();
        sma_wp         = '0;
        sma_fast_sum   = '0;
        sma_slow_sum   = '0;
        sma_seen       = '0;
        sma_fill       = 0;
        sma_prev_sign  = 0;
        sma_sign_valid = 1'b0;
    endfunction

    // Advance the SMA predictor by one sample and queue any crossing it causes
    function automatic void predict_crossing(input mac_pkg::t_in req);
        logic [7:0]      back_fast;
        logic [7:0]      back_slow;
        logic [31:0]     idx;
        logic            win_ok;
        longint unsigned lhs;
        longint unsigned rhs;
        int              sgn;
        mac_pkg::t_out   res;
        win_ok = (sma_fast_win != 0) && (sma_fast_win < sma_slow_win) &&
                 (sma_slow_win <= mac_pkg::MAX_WINDOW);
        if (req.first_of_series) series_restart();
        idx = sma_seen;
        // sums only move while the windows are usable
        if (win_ok) begin
            back_fast = sma_wp - sma_fast_win;
            back_slow = sma_wp - sma_slow_win[7:0];
            sma_fast_sum = sma_fast_sum + req.sample;
            if (sma_fill >= sma_fast_win) sma_fast_sum = sma_fast_sum - sma_ring[back_fast];
            sma_slow_sum = sma_slow_sum + req.sample;
            if (sma_fill >= sma_slow_win) sma_slow_sum = sma_slow_sum - sma_ring[back_slow];
        end
        sma_ring[sma_wp] = req.sample;
        sma_wp = sma_wp + 8'd1;
        if (sma_fill < mac_pkg::MAX_WINDOW) sma_fill++;
        sma_seen = idx + 32'd1;
        // cross-multiplied comparison of the two averages
        if (win_ok && sma_fill >= sma_slow_win) begin
            lhs = 64'(sma_fast_sum) * 64'(sma_slow_win);
            rhs = 64'(sma_slow_sum) * 64'(sma_fast_win);
            sgn = (lhs > rhs) ? 1 : ((lhs < rhs) ? -1 : 0);
            if (sma_sign_valid) begin
                if (sma_prev_sign <= 0 && sgn > 0) begin
                    res.sample_index = idx;
                    res.cross_kind   = mac_pkg::CROSS_GOLDEN;
                    pending_crosses  = {pending_crosses, res};
                end else if (sma_prev_sign >= 0 && sgn < 0) begin
                    res.sample_index = idx;
                    res.cross_kind   = mac_pkg::CROSS_DEATH;
                    pending_crosses  = {pending_crosses, res};
                end
            end
            sma_prev_sign  = sgn;
            sma_sign_valid = 1'b1;
        end
    endfunction

    // Monitor: register writes, accepted samples and delivered crossings
    always @(posedge clk) begin : monitor
        mac_pkg::t_out want;
        if (!rst_n) begin
            in_fire      = 1'b0;
            sma_fast_win = mac_pkg::FAST_RESET;
            sma_slow_win = mac_pkg::SLOW_RESET;
            series_restart();
        end else begin
            if (cfg_valid && cfg_ready) begin
                n_cfg++;
                case (cfg_index)
                    mac_pkg::REG_FAST_LEN: begin
                        sma_fast_win = cfg_data[mac_pkg::FAST_W-1:0];
                        series_restart();
                    end
                    mac_pkg::REG_SLOW_LEN: begin
                        sma_slow_win = cfg_data;
                        series_restart();
                    end
                    default: ;
                endcase
            end
            in_fire = in_valid && !in_stall;
            if (in_valid && in_stall) n_in_held++;
            if (in_fire) begin
                n_samples++;
                predict_crossing(in_data);
            end
            if (out_valid && !out_stall) begin
                if (pending_crosses.size() == 0) begin
                    $error("crossing at sample_index %0d with none expected",
                           out_data.sample_index);
                    n_err++;
                end else begin
                    want = pending_crosses.pop_front();
                    if (out_data.sample_index !== want.sample_index) begin
                        $error("sample_index: expected %0d, got %0d",
                               want.sample_index, out_data.sample_index);
                        n_err++;
                    end
                    if (out_data.cross_kind !== want.cross_kind) begin
                        $error("cross_kind: expected %0d, got %0d",
                               want.cross_kind, out_data.cross_kind);
                        n_err++;
                    end
                end
                if (out_data.cross_kind == mac_pkg::CROSS_DEATH) n_death++;
                else n_golden++;
            end
        end
    end

    // Driver: offers the backlog in bursts with idle gaps between them
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fire) begin
            if (in_fire) void'(sample_backlog.pop_front());
            if (burst_left == 0 && gap_left == 0) begin
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                         : $urandom_range(1, 12);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
            if (burst_left > 0 && sample_backlog.size() > 0) begin
                in_valid <= 1'b1;
                in_data  <= sample_backlog[0];
                burst_left--;
            end else begin
                in_valid <= 1'b0;
                if (burst_left == 0 && gap_left > 0) gap_left--;
            end
        end
    end

    // Output stall: shifting random patterns, plus a long hold when asked
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 4));
                mode_left  = $urandom_range(16, 160);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HALF:  out_stall <= 1'($urandom_range(0, 1));
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 7) != 0);
                    default:     out_stall <= ~out_stall;
                endcase
            end
        end
    end

    task automatic queue_sample(input logic [mac_pkg::SAMPLE_BITS-1:0] value,
                                input logic first);
        mac_pkg::t_in req;
        req.sample          = value;
        req.first_of_series = first;
        sample_backlog      = {sample_backlog, req};
    endtask

    // Trending random walk with occasional jumps, extremes and series restarts
    task automatic queue_walk(input int count, input int step_max, input int restart_odds);
        int level;
        int trend;
        int seg_left;
        int v;
        level    = $urandom_range(0, 65535);
        trend    = 1;
        seg_left = 0;
        repeat (count) begin
            if (seg_left == 0) begin
                trend    = ($urandom_range(0, 1) == 1) ? 1 : -1;
                seg_left = $urandom_range(3, 60);
            end
            seg_left--;
            case ($urandom_range(0, 99))
                0:       v = 0;
                1:       v = 65535;
                2, 3, 4: v = $urandom_range(0, 65535);
                default: v = level + trend * int'($urandom_range(0, step_max))
                             + int'($urandom_range(0, step_max / 4))
                             - int'($urandom_range(0, step_max / 4));
            endcase
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
            level = v;
            queue_sample(16'(v), (restart_odds != 0) &&
                                 ($urandom_range(0, restart_odds - 1) == 0));
        end
    endtask

    task automatic cfg_write(input logic [mac_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mac_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait for the backlog to drain and every crossing to arrive, then let
    // the pipeline empty out
    task automatic settle();
        int waited;
        waited = 0;
        while ((sample_backlog.size() != 0 || in_valid || pending_crosses.size() != 0)
               && waited < SETTLE_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        if (waited >= SETTLE_LIMIT) begin
            $error("%0d crossings still outstanding", pending_crosses.size());
            n_err++;
            pending_crosses.delete();
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Stimulus sequence
    initial begin
        int fw;
        int sw;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset windows, 5 over 20
        queue_walk(80, 1500, 150);
        settle();

        // fast 1 over slow 2: both crossing kinds, equal averages, extremes,
        // restart in mid series
        cfg_write(mac_pkg::REG_FAST_LEN, 9'd1);
        cfg_write(mac_pkg::REG_SLOW_LEN, 9'd2);
        queue_sample(16'h0000, 1'b1);
        queue_sample(16'hFFFF, 1'b0);
        queue_sample(16'h0000, 1'b0);
        queue_sample(16'hFFFF, 1'b0);
        queue_sample(16'hFFFF, 1'b0);
        queue_sample(16'h0000, 1'b0);
        queue_sample(16'h0000, 1'b0);
        queue_sample(16'hFFFF, 1'b0);
        queue_sample(16'hFFFF, 1'b1);
        queue_sample(16'h0000, 1'b0);
        queue_sample(16'hFFFF, 1'b0);
        settle();

        // rewriting the same value still restarts the series
        cfg_write(mac_pkg::REG_SLOW_LEN, 9'd2);
        queue_sample(16'hFFFF, 1'b0);
        queue_sample(16'h0000, 1'b0);
        queue_sample(16'hFFFF, 1'b0);
        settle();

        // unknown register indexes leave windows and series alone
        cfg_write(REG_LAST, 9'h1FF);
        cfg_write(REG_SPARE, 9'd0);
        queue_sample(16'h0000, 1'b0);
        settle();

        // unusable windows: fast zero, fast equal to slow, slow past the ring
        cfg_write(mac_pkg::REG_FAST_LEN, 9'd0);
        queue_sample(16'hFFFF, 1'b0);
        queue_sample(16'h0000, 1'b0);
        queue_sample(16'hFFFF, 1'b0);
        settle();
        cfg_write(mac_pkg::REG_FAST_LEN, 9'd2);
        queue_sample(16'h0000, 1'b0);
        queue_sample(16'hFFFF, 1'b0);
        queue_sample(16'h0000, 1'b0);
        settle();
        cfg_write(mac_pkg::REG_SLOW_LEN, 9'h1FF);
        queue_sample(16'hFFFF, 1'b0);
        queue_sample(16'h0000, 1'b0);
        queue_sample(16'hFFFF, 1'b0);
        settle();

        // smallest windows
        cfg_write(mac_pkg::REG_FAST_LEN, 9'd1);
        cfg_write(mac_pkg::REG_SLOW_LEN, 9'd2);
        queue_walk(100, 3000, 100);
        settle();

        // largest windows; bit 8 of the data is dropped for the fast window
        cfg_write(mac_pkg::REG_FAST_LEN, 9'h1FF);
        cfg_write(mac_pkg::REG_SLOW_LEN, 9'd256);
        queue_walk(300, 1500, 0);
        settle();

        // random usable windows
        repeat (4) begin
            fw = $urandom_range(1, 15);
            sw = fw + $urandom_range(1, 40);
            cfg_write(mac_pkg::REG_SLOW_LEN, mac_pkg::CFG_DATA_W'(sw));
            cfg_write(mac_pkg::REG_FAST_LEN, mac_pkg::CFG_DATA_W'(fw));
            queue_walk(80, 2000, 120);
            settle();
        end

        // fast wider than slow
        cfg_write(mac_pkg::REG_FAST_LEN, 9'd200);
        cfg_write(mac_pkg::REG_SLOW_LEN, 9'd100);
        queue_walk(30, 2000, 0);
        settle();

        // back-pressure: a crossing on nearly every sample while the output
        // holds off, so the block has to stall its input
        cfg_write(mac_pkg::REG_FAST_LEN, 9'd1);
        cfg_write(mac_pkg::REG_SLOW_LEN, 9'd2);
        for (int k = 0; k < 150; k++) begin
            queue_sample((k % 2 == 1) ? 16'($urandom_range(40000, 65535))
                                      : 16'($urandom_range(0, 20000)), k == 0);
        end
        hold_asks++;
        settle();

        $display("covered %0d samples and %0d register writes; %0d golden, %0d death",
                 n_samples, n_cfg, n_golden, n_death);
        $display("input held off by the block on %0d cycles", n_in_held);
        if (n_err == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("timeout waiting on the block");
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
